// ===== design/tmog_pkg.sv =====
// shared types, constants and codes of the over-temperature guard
package tmog_pkg;

    // field widths
    localparam int TEMP_W   = 10;
    localparam int SIDX_IN_W = 2;
    localparam int LIMIT_W  = 8;
    localparam int DROP_W   = 6;
    localparam int MS_W     = 16;
    localparam int FAN_W    = 16;
    localparam int TIMER_W  = 24;
    localparam int ACTION_W = 2;
    localparam int NUM_LIMITS = 4;

    // parameter defaults
    localparam int NUM_SENSORS_DEF = 4;
    localparam int AVG_DEPTH_DEF   = 3;
    localparam int RETRY_LIMIT_DEF = 5;

    // qualification window and outlier span
    localparam logic signed [TEMP_W-1:0] FIRST_LOW  = -10'sd25;
    localparam logic signed [TEMP_W-1:0] FIRST_HIGH = 10'sd120;
    localparam int OUTLIER_SPAN = 8;

    // configuration bus
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;
    localparam int REG_IDX_W = 3;

    // register indexes
    localparam logic [REG_IDX_W-1:0] REG_LIMIT_FRONT = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_LIMIT_MAIN  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_LIMIT_LENS  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_LIMIT_DIE   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_RECOVERY    = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_CRIT_RISE   = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_SHUTDOWN    = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_PERIOD      = 3'd7;

    // register reset values
    localparam logic [LIMIT_W-1:0] LIMIT_FRONT_RST = 8'd70;
    localparam logic [LIMIT_W-1:0] LIMIT_MAIN_RST  = 8'd80;
    localparam logic [LIMIT_W-1:0] LIMIT_LENS_RST  = 8'd80;
    localparam logic [LIMIT_W-1:0] LIMIT_DIE_RST   = 8'd65;
    localparam logic [DROP_W-1:0]  RECOVERY_RST    = 6'd5;
    localparam logic [DROP_W-1:0]  CRIT_RISE_RST   = 6'd5;
    localparam logic [MS_W-1:0]    SHUTDOWN_RST    = 16'd10000;
    localparam logic [MS_W-1:0]    PERIOD_RST      = 16'd1000;

    // fan command codes
    localparam logic [ACTION_W-1:0] FAN_NONE    = 2'd0;
    localparam logic [ACTION_W-1:0] FAN_MAX     = 2'd1;
    localparam logic [ACTION_W-1:0] FAN_RESTORE = 2'd2;

    // configuration handed from the register file to the core
    typedef struct packed {
        logic [NUM_LIMITS-1:0][LIMIT_W-1:0] limit;
        logic [DROP_W-1:0]                  recovery_drop;
        logic [DROP_W-1:0]                  critical_rise;
        logic [MS_W-1:0]                    shutdown_delay_ms;
        logic [MS_W-1:0]                    report_period_ms;
    } cfg_t;

endpackage

// ===== design/tmog_cfg.sv =====
// configuration register file behind the register bus
module tmog_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tmog_pkg::ADDR_W-1:0]   paddr,
    input  logic [tmog_pkg::DATA_W-1:0]   pwdata,
    output logic [tmog_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output tmog_pkg::cfg_t                cfg
);
    import tmog_pkg::*;

    cfg_t                 cfg_reg;
    cfg_t                 cfg_next;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign reg_idx = paddr[ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    // write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_LIMIT_FRONT: cfg_next.limit[0] = pwdata[LIMIT_W-1:0];
                REG_LIMIT_MAIN:  cfg_next.limit[1] = pwdata[LIMIT_W-1:0];
                REG_LIMIT_LENS:  cfg_next.limit[2] = pwdata[LIMIT_W-1:0];
                REG_LIMIT_DIE:   cfg_next.limit[3] = pwdata[LIMIT_W-1:0];
                REG_RECOVERY:    cfg_next.recovery_drop = pwdata[DROP_W-1:0];
                REG_CRIT_RISE:   cfg_next.critical_rise = pwdata[DROP_W-1:0];
                REG_SHUTDOWN:    cfg_next.shutdown_delay_ms = pwdata[MS_W-1:0];
                REG_PERIOD:      cfg_next.report_period_ms = pwdata[MS_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    // register storage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.limit[0]          <= LIMIT_FRONT_RST;
            cfg_reg.limit[1]          <= LIMIT_MAIN_RST;
            cfg_reg.limit[2]          <= LIMIT_LENS_RST;
            cfg_reg.limit[3]          <= LIMIT_DIE_RST;
            cfg_reg.recovery_drop     <= RECOVERY_RST;
            cfg_reg.critical_rise     <= CRIT_RISE_RST;
            cfg_reg.shutdown_delay_ms <= SHUTDOWN_RST;
            cfg_reg.report_period_ms  <= PERIOD_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // read mux
    always_comb
    begin
        unique case (reg_idx)
            REG_LIMIT_FRONT: prdata = DATA_W'(cfg_reg.limit[0]);
            REG_LIMIT_MAIN:  prdata = DATA_W'(cfg_reg.limit[1]);
            REG_LIMIT_LENS:  prdata = DATA_W'(cfg_reg.limit[2]);
            REG_LIMIT_DIE:   prdata = DATA_W'(cfg_reg.limit[3]);
            REG_RECOVERY:    prdata = DATA_W'(cfg_reg.recovery_drop);
            REG_CRIT_RISE:   prdata = DATA_W'(cfg_reg.critical_rise);
            REG_SHUTDOWN:    prdata = DATA_W'(cfg_reg.shutdown_delay_ms);
            REG_PERIOD:      prdata = DATA_W'(cfg_reg.report_period_ms);
            default:         prdata = '0;
        endcase
    end

endmodule

// ===== design/thermal_monitor_overtemp_guard_core.sv =====
// over-temperature guard: reading qualification, averaging, alarms and fan command
// a reading is captured in the item register and, once the result register is free, is offered as a result
// throughput: one reading per cycle while the result is not stalled; the step is one pass from the item register
//   to the result register, with per-sensor state updated on the same edge
// the rounded average uses one constant-reciprocal multiply in that pass
// reset clears all per-sensor and global state and loads the register defaults;
//   sample history is not reset and is always refilled before it is averaged
module thermal_monitor_overtemp_guard_core #(
    parameter int NUM_SENSORS = tmog_pkg::NUM_SENSORS_DEF,
    parameter int AVG_DEPTH   = tmog_pkg::AVG_DEPTH_DEF,
    parameter int RETRY_LIMIT = tmog_pkg::RETRY_LIMIT_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // register bus
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [tmog_pkg::ADDR_W-1:0]        paddr,
    input  logic [tmog_pkg::DATA_W-1:0]        pwdata,
    output logic [tmog_pkg::DATA_W-1:0]        prdata,
    output logic                               pready,
    // reading channel
    input  logic                               sample_valid,
    output logic                               sample_stall,
    input  logic [tmog_pkg::SIDX_IN_W-1:0]     sensor_index,
    input  logic                               read_ok,
    input  logic signed [tmog_pkg::TEMP_W-1:0] reading,
    input  logic [tmog_pkg::FAN_W-1:0]         fan_speed_now,
    // result channel
    output logic                               result_valid,
    input  logic                               result_stall,
    output logic [tmog_pkg::SIDX_IN_W-1:0]     sensor_echo,
    output logic                               sample_kept,
    output logic                               history_cleared,
    output logic                               report_valid,
    output logic signed [tmog_pkg::TEMP_W-1:0] average_out,
    output logic                               sensor_in_alarm,
    output logic                               any_in_alarm,
    output logic [tmog_pkg::ACTION_W-1:0]      fan_action,
    output logic [tmog_pkg::FAN_W-1:0]         fan_restore_speed,
    output logic                               shutdown_request
);
    import tmog_pkg::*;

    localparam int SIDX_W = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;
    localparam int WP_W   = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
    localparam int RC_W   = $clog2(RETRY_LIMIT + 1);
    localparam int ACNT_W = $clog2(NUM_SENSORS + 1);
    localparam int SUM_W  = TEMP_W + $clog2(AVG_DEPTH) + 1;
    localparam int NUM_W  = SUM_W + 1;
    localparam int DIV_L  = $clog2(2 * AVG_DEPTH);
    localparam int DIV_SH = NUM_W + DIV_L;
    localparam int PROD_W = NUM_W + DIV_SH + 1;
    localparam int CMP_W  = TEMP_W + 2;
    localparam logic [DIV_SH:0] RECIP =
        (DIV_SH+1)'(((1 << DIV_SH) + 2 * AVG_DEPTH - 1) / (2 * AVG_DEPTH));
    localparam logic signed [TEMP_W:0] SPAN_HI = (TEMP_W+1)'(OUTLIER_SPAN);
    localparam logic signed [TEMP_W:0] SPAN_LO = -SPAN_HI;
    localparam logic [TIMER_W-1:0] TIMER_MAX = '1;

    cfg_t cfg;

    tmog_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // item register
    logic                      item_valid_reg;
    logic [SIDX_IN_W-1:0]      item_sensor_reg;
    logic                      item_ok_reg;
    logic signed [TEMP_W-1:0]  item_reading_reg;
    logic [FAN_W-1:0]          item_fan_reg;

    // per-sensor and global state
    logic signed [TEMP_W-1:0]  hist_reg [NUM_SENSORS][AVG_DEPTH];
    logic [WP_W-1:0]           wp_reg [NUM_SENSORS];
    logic [RC_W-1:0]           rc_reg [NUM_SENSORS];
    logic signed [TEMP_W-1:0]  last_avg_reg [NUM_SENSORS];
    logic                      known_reg [NUM_SENSORS];
    logic                      alarm_reg [NUM_SENSORS];
    logic [TIMER_W-1:0]        timer_reg [NUM_SENSORS];
    logic [ACNT_W-1:0]         alarm_cnt_reg;
    logic [FAN_W-1:0]          saved_fan_reg;

    // result register
    logic                      res_valid_reg;
    logic [SIDX_IN_W-1:0]      res_sensor_reg;
    logic                      res_kept_reg;
    logic                      res_cleared_reg;
    logic                      res_report_reg;
    logic signed [TEMP_W-1:0]  res_avg_reg;
    logic                      res_alarm_reg;
    logic                      res_any_reg;
    logic [ACTION_W-1:0]       res_action_reg;
    logic [FAN_W-1:0]          res_restore_reg;
    logic                      res_shut_reg;

    // handshake
    logic out_free;
    logic step_go;
    logic take_item;

    assign out_free     = !res_valid_reg || !result_stall;
    assign step_go      = item_valid_reg && out_free;
    assign sample_stall = item_valid_reg && !out_free;
    assign take_item    = sample_valid && !sample_stall;

    // step datapath signals
    logic [SIDX_W-1:0]         s_idx;
    logic                      in_range;
    logic [WP_W-1:0]           wp_cur;
    logic [RC_W-1:0]           rc_cur;
    logic [RC_W-1:0]           rc_inc;
    logic signed [TEMP_W-1:0]  last_avg_cur;
    logic                      known_cur;
    logic                      alarm_cur;
    logic [TIMER_W-1:0]        timer_cur;
    logic signed [TEMP_W:0]    diff;
    logic                      qual;
    logic                      kept;
    logic                      failed;
    logic                      exhausted;
    logic                      wrap;
    logic                      report;
    logic signed [SUM_W-1:0]   sum;
    logic                      sum_neg;
    logic [SUM_W-1:0]          mag;
    logic [NUM_W-1:0]          num;
    logic [PROD_W-1:0]         prod;
    logic [TEMP_W-1:0]         avg_mag;
    logic signed [TEMP_W-1:0]  avg_new;
    logic signed [CMP_W-1:0]   avg_x;
    logic signed [CMP_W-1:0]   lim_x;
    logic signed [CMP_W-1:0]   crit_x;
    logic signed [CMP_W-1:0]   low_x;
    logic [TIMER_W:0]          timer_sum;
    logic [TIMER_W-1:0]        timer_sat;
    logic                      enter;
    logic                      leave;
    logic [ACNT_W-1:0]         cnt_dec;

    logic [WP_W-1:0]           wp_next;
    logic [RC_W-1:0]           rc_next;
    logic signed [TEMP_W-1:0]  last_avg_next;
    logic                      known_next;
    logic                      alarm_next;
    logic [TIMER_W-1:0]        timer_next;
    logic [ACNT_W-1:0]         alarm_cnt_next;
    logic [FAN_W-1:0]          saved_fan_next;
    logic [ACTION_W-1:0]       action;
    logic [FAN_W-1:0]          restore;
    logic                      shut;

    // select the addressed sensor's state
    always_comb
    begin
        s_idx        = SIDX_W'(item_sensor_reg);
        in_range     = ({1'b0, item_sensor_reg} < (SIDX_IN_W+1)'(NUM_SENSORS));
        wp_cur       = wp_reg[s_idx];
        rc_cur       = rc_reg[s_idx];
        last_avg_cur = last_avg_reg[s_idx];
        known_cur    = known_reg[s_idx];
        alarm_cur    = alarm_reg[s_idx];
        timer_cur    = timer_reg[s_idx];
    end

    // qualification and retry counting
    always_comb
    begin
        diff = (TEMP_W+1)'(item_reading_reg) - (TEMP_W+1)'(last_avg_cur);
        if (known_cur)
        begin
            qual = (diff > SPAN_LO) && (diff < SPAN_HI);
        end
        else
        begin
            qual = (item_reading_reg > FIRST_LOW) && (item_reading_reg < FIRST_HIGH);
        end
        kept      = in_range && item_ok_reg && qual;
        failed    = in_range && !kept;
        rc_inc    = rc_cur + 1'b1;
        exhausted = (rc_inc >= RC_W'(RETRY_LIMIT));
        wrap      = (wp_cur == WP_W'(AVG_DEPTH - 1));
        report    = kept && wrap;
    end

    // rounded mean: the new reading fills the last slot
    always_comb
    begin
        sum = '0;
        for (int j = 0; j < AVG_DEPTH; j++)
        begin
            if (WP_W'(j) == wp_cur)
            begin
                sum = sum + SUM_W'(item_reading_reg);
            end
            else
            begin
                sum = sum + SUM_W'(hist_reg[s_idx][j]);
            end
        end
        sum_neg = sum[SUM_W-1];
        mag     = sum_neg ? (~sum + 1'b1) : sum;
        num     = {mag, 1'b0} + NUM_W'(AVG_DEPTH);
        prod    = PROD_W'(num) * PROD_W'(RECIP);
        avg_mag = prod[DIV_SH +: TEMP_W];
        avg_new = sum_neg ? (~avg_mag + 1'b1) : avg_mag;
    end

    // thresholds, critical timer and hysteresis
    always_comb
    begin
        avg_x     = CMP_W'(avg_new);
        lim_x     = CMP_W'(signed'(cfg.limit[item_sensor_reg]));
        crit_x    = lim_x + signed'(CMP_W'(cfg.critical_rise));
        low_x     = lim_x - signed'(CMP_W'(cfg.recovery_drop));
        timer_sum = {1'b0, timer_cur} + (TIMER_W+1)'(cfg.report_period_ms);
        timer_sat = timer_sum[TIMER_W] ? TIMER_MAX : timer_sum[TIMER_W-1:0];
        enter     = report && !alarm_cur && (avg_x > lim_x);
        leave     = report && alarm_cur && (avg_x < low_x);
        cnt_dec   = (alarm_cnt_reg != '0) ? (alarm_cnt_reg - 1'b1) : '0;
    end

    // next state and result fields
    always_comb
    begin
        wp_next        = wp_cur;
        rc_next        = rc_cur;
        last_avg_next  = last_avg_cur;
        known_next     = known_cur;
        alarm_next     = alarm_cur;
        timer_next     = timer_cur;
        alarm_cnt_next = alarm_cnt_reg;
        saved_fan_next = saved_fan_reg;
        action         = FAN_NONE;
        restore        = '0;
        shut           = 1'b0;

        if (kept)
        begin
            rc_next = '0;
            wp_next = wrap ? '0 : (wp_cur + 1'b1);
        end
        else if (failed)
        begin
            rc_next = exhausted ? '0 : rc_inc;
            wp_next = exhausted ? '0 : wp_cur;
        end

        if (report)
        begin
            last_avg_next = avg_new;
            known_next    = 1'b1;
            if (avg_x > crit_x)
            begin
                timer_next = timer_sat;
                shut       = (timer_sat > TIMER_W'(cfg.shutdown_delay_ms));
            end
            else
            begin
                timer_next = '0;
            end
        end

        if (enter)
        begin
            alarm_next     = 1'b1;
            alarm_cnt_next = alarm_cnt_reg + 1'b1;
            if (alarm_cnt_reg == '0)
            begin
                saved_fan_next = item_fan_reg;
                action         = FAN_MAX;
            end
        end
        else if (leave)
        begin
            alarm_next     = 1'b0;
            alarm_cnt_next = cnt_dec;
            if (cnt_dec == '0)
            begin
                action  = FAN_RESTORE;
                restore = saved_fan_reg;
            end
        end
    end

    // item register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (take_item)
        begin
            item_valid_reg <= 1'b1;
        end
        else if (step_go)
        begin
            item_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_item)
        begin
            item_sensor_reg  <= sensor_index;
            item_ok_reg      <= read_ok;
            item_reading_reg <= reading;
            item_fan_reg     <= fan_speed_now;
        end
    end

    // per-sensor and global state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SENSORS; i++)
            begin
                wp_reg[i]       <= '0;
                rc_reg[i]       <= '0;
                last_avg_reg[i] <= '0;
                known_reg[i]    <= 1'b0;
                alarm_reg[i]    <= 1'b0;
                timer_reg[i]    <= '0;
            end
            alarm_cnt_reg <= '0;
            saved_fan_reg <= '0;
        end
        else if (step_go)
        begin
            if (in_range)
            begin
                wp_reg[s_idx]       <= wp_next;
                rc_reg[s_idx]       <= rc_next;
                last_avg_reg[s_idx] <= last_avg_next;
                known_reg[s_idx]    <= known_next;
                alarm_reg[s_idx]    <= alarm_next;
                timer_reg[s_idx]    <= timer_next;
            end
            alarm_cnt_reg <= alarm_cnt_next;
            saved_fan_reg <= saved_fan_next;
        end
    end

    // sample history, written only by kept readings
    always_ff @(posedge clk)
    begin
        if (step_go && kept)
        begin
            hist_reg[s_idx][wp_cur] <= item_reading_reg;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (step_go)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_go)
        begin
            res_sensor_reg  <= item_sensor_reg;
            res_kept_reg    <= kept;
            res_cleared_reg <= failed && exhausted;
            res_report_reg  <= report;
            res_avg_reg     <= in_range ? last_avg_next : '0;
            res_alarm_reg   <= in_range && alarm_next;
            res_any_reg     <= (alarm_cnt_next != '0);
            res_action_reg  <= action;
            res_restore_reg <= restore;
            res_shut_reg    <= shut;
        end
    end

    assign result_valid      = res_valid_reg;
    assign sensor_echo       = res_sensor_reg;
    assign sample_kept       = res_kept_reg;
    assign history_cleared   = res_cleared_reg;
    assign report_valid      = res_report_reg;
    assign average_out       = res_avg_reg;
    assign sensor_in_alarm   = res_alarm_reg;
    assign any_in_alarm      = res_any_reg;
    assign fan_action        = res_action_reg;
    assign fan_restore_speed = res_restore_reg;
    assign shutdown_request  = res_shut_reg;

endmodule

// ===== design/tmog_checker.sv =====
// port-level checks of the over-temperature guard, bound to the top level
module tmog_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               result_valid,
    input logic                               result_stall,
    input logic                               sample_kept,
    input logic                               history_cleared,
    input logic                               report_valid,
    input logic                               sensor_in_alarm,
    input logic                               any_in_alarm,
    input logic [tmog_pkg::ACTION_W-1:0]      fan_action,
    input logic                               shutdown_request
);
    import tmog_pkg::*;

    // a stalled result stays offered and unchanged
    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid
            && $stable({sample_kept, history_cleared, report_valid, sensor_in_alarm,
                        any_in_alarm, fan_action, shutdown_request}))
        else $error("stalled result changed");

    // a history clear only follows a rejected attempt
    a_clear_not_kept: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && history_cleared |-> !sample_kept && !report_valid)
        else $error("history cleared on a kept reading");

    // shutdown is flagged only with a fresh average
    a_shut_on_report: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && shutdown_request |-> report_valid)
        else $error("shutdown request outside a report");

    // fan to maximum only when this sensor just entered alarm
    a_fan_max: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (fan_action == FAN_MAX) |-> sensor_in_alarm && any_in_alarm)
        else $error("fan maximum without alarm");

    // restore only once no sensor is in alarm
    a_fan_restore: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (fan_action == FAN_RESTORE) |-> !any_in_alarm && !sensor_in_alarm)
        else $error("fan restore while still in alarm");

endmodule

bind thermal_monitor_overtemp_guard_core tmog_checker u_tmog_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .result_valid     (result_valid),
    .result_stall     (result_stall),
    .sample_kept      (sample_kept),
    .history_cleared  (history_cleared),
    .report_valid     (report_valid),
    .sensor_in_alarm  (sensor_in_alarm),
    .any_in_alarm     (any_in_alarm),
    .fan_action       (fan_action),
    .shutdown_request (shutdown_request)
);
